### rtl/fixed_point_alu_q24_8_macros.svh
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8 assertion macros
// Shared concurrent assertion forms for the fixed-point ALU.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_Q24_8_MACROS_SVH
`define FIXED_POINT_ALU_Q24_8_MACROS_SVH

// same-cycle implication, masked during reset
`define FALU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("falu assertion failed");

// next-cycle implication, masked during reset
`define FALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("falu assertion failed");

`endif

### rtl/falu_pkg.sv
// ----------------------------------------------------------------------------
// falu_pkg
// Operation codes, result type and saturation helpers for the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package falu_pkg;

    typedef enum logic [3:0] {
        K_ADD     = 4'd0,
        K_SUB     = 4'd1,
        K_MUL     = 4'd2,
        K_DIV     = 4'd3,
        K_GT      = 4'd4,
        K_LT      = 4'd5,
        K_GE      = 4'd6,
        K_LE      = 4'd7,
        K_EQ      = 4'd8,
        K_NE      = 4'd9,
        K_INC     = 4'd10,
        K_DEC     = 4'd11,
        K_MIN     = 4'd12,
        K_MAX     = 4'd13,
        K_TOINT   = 4'd14,
        K_FROMINT = 4'd15
    } t_kind;

    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic        fault;
        logic [31:0] value;
    } t_sat;

    // sign and magnitude to saturated 32-bit two's complement
    function automatic t_sat sat_mag(input logic neg, input logic [63:0] mag);
        t_sat res;
        res.fault = 1'b0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                res.fault = 1'b1;
                res.value = VAL_MIN;
            end else begin
                res.value = 32'(-mag);
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                res.fault = 1'b1;
                res.value = VAL_MAX;
            end else begin
                res.value = mag[31:0];
            end
        end
        return res;
    endfunction

    // wide signed value to saturated 32-bit two's complement
    function automatic t_sat sat_s64(input logic signed [63:0] v);
        t_sat res;
        res.fault = 1'b0;
        res.value = v[31:0];
        if (v > 64'sh7FFF_FFFF) begin
            res.fault = 1'b1;
            res.value = VAL_MAX;
        end else if (v < -64'sh8000_0000) begin
            res.fault = 1'b1;
            res.value = VAL_MIN;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/falu_div.sv
// ----------------------------------------------------------------------------
// falu_div
// Pipelined restoring divider, one quotient bit per stage, then a
// round-half-up stage on the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module falu_div #(
    parameter int NUM_W = 40
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [31:0]      i_den,
    output logic      [NUM_W:0]   o_quo
);

    logic [31:0]      r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [31:0]      r_den [NUM_W];
    logic [NUM_W:0]   r_quo;

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [31:0]      rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [31:0]      den_in;
        logic [32:0]      t;
        logic             ge;
        logic [31:0]      n_rem;
        logic [NUM_W-1:0] n_nq;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign nq_in  = r_nq[k-1];
            assign den_in = r_den[k-1];
        end

        always_comb begin
            t     = {rem_in, nq_in[NUM_W-1]};
            ge    = t >= {1'b0, den_in};
            n_rem = ge ? 32'(t - {1'b0, den_in}) : t[31:0];
            n_nq  = {nq_in[NUM_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_nq[k]  <= n_nq;
                r_den[k] <= den_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if ({r_rem[NUM_W-1], 1'b0} >= {1'b0, r_den[NUM_W-1]}) begin
                r_quo <= {1'b0, r_nq[NUM_W-1]} + 1'b1;
            end else begin
                r_quo <= {1'b0, r_nq[NUM_W-1]};
            end
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

### rtl/fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed 32-bit fixed-point ALU, FRACTION_BITS fraction bits, saturating.
// ----------------------------------------------------------------------------
// channel | dir | tdata              | tuser
// s_axis  | in  | operand_a, operand_b | kind
// m_axis  | out | value              | compare_true, fault
//
// One beat per cycle in and out while the output is not stalled. The pipeline
// depth is set by the divider: one restoring step per numerator bit (32 +
// FRACTION_BITS), plus the input, rounding and output registers.
// All stages share one enable; a stalled output freezes the whole pipe.
// Synchronous active-low reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_point_alu_q24_8_macros.svh"

module fixed_point_alu_q24_8 #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    input  wire logic [3:0]  i_s_axis_tuser,   // kind[3:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [31:0] o_m_axis_tdata,   // value[31:0]
    output logic      [1:0]  o_m_axis_tuser    // compare_true[0], fault[1]
);

    localparam int NUM_W = 32 + FRACTION_BITS;
    localparam int DLY_N = NUM_W;

    logic en;
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage 1: input register
    logic                r1_v;
    falu_pkg::t_kind     r1_kind;
    logic signed [31:0]  r1_a, r1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind <= falu_pkg::t_kind'(i_s_axis_tuser);
            r1_a    <= i_s_axis_tdata[31:0];
            r1_b    <= i_s_axis_tdata[63:32];
        end
    end

    logic [31:0] amag, bmag;
    logic        res_neg;
    assign amag    = r1_a[31] ? 32'(-r1_a) : r1_a;
    assign bmag    = r1_b[31] ? 32'(-r1_b) : r1_b;
    assign res_neg = r1_a[31] ^ r1_b[31];

    logic [NUM_W:0] div_quo;
    falu_div #(.NUM_W(NUM_W)) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({amag, FRACTION_BITS'(0)}),
        .i_den (bmag),
        .o_quo (div_quo)
    );

    // stage 2: simple ops and magnitude product
    falu_pkg::t_sat n2_res;
    logic           n2_cmp;

    always_comb begin
        n2_res = '0;
        n2_cmp = 1'b0;
        case (r1_kind)
            falu_pkg::K_ADD:     n2_res = falu_pkg::sat_s64(64'(r1_a) + 64'(r1_b));
            falu_pkg::K_SUB:     n2_res = falu_pkg::sat_s64(64'(r1_a) - 64'(r1_b));
            falu_pkg::K_GT:      n2_cmp = r1_a > r1_b;
            falu_pkg::K_LT:      n2_cmp = r1_a < r1_b;
            falu_pkg::K_GE:      n2_cmp = r1_a >= r1_b;
            falu_pkg::K_LE:      n2_cmp = r1_a <= r1_b;
            falu_pkg::K_EQ:      n2_cmp = r1_a == r1_b;
            falu_pkg::K_NE:      n2_cmp = r1_a != r1_b;
            falu_pkg::K_INC:     n2_res = falu_pkg::sat_s64(64'(r1_a) + 64'sd1);
            falu_pkg::K_DEC:     n2_res = falu_pkg::sat_s64(64'(r1_a) - 64'sd1);
            falu_pkg::K_MIN:     n2_res.value = (r1_a < r1_b) ? r1_a : r1_b;
            falu_pkg::K_MAX:     n2_res.value = (r1_a > r1_b) ? r1_a : r1_b;
            falu_pkg::K_TOINT:   n2_res.value = r1_a >>> FRACTION_BITS;
            falu_pkg::K_FROMINT: n2_res = falu_pkg::sat_s64(64'(r1_a) <<< FRACTION_BITS);
            default:             n2_res = '0;
        endcase
    end

    logic            r2_v;
    falu_pkg::t_kind r2_kind;
    falu_pkg::t_sat  r2_res;
    logic            r2_cmp;
    logic            r2_neg;
    logic            r2_dz;
    logic [63:0]     r2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_kind <= r1_kind;
            r2_res  <= n2_res;
            r2_cmp  <= n2_cmp;
            r2_neg  <= res_neg;
            r2_dz   <= (r1_b == '0);
            r2_prod <= 64'(amag) * 64'(bmag);
        end
    end

    // stage 3: product rounding merged, then delay line to meet the divider
    typedef struct packed {
        logic            v;
        falu_pkg::t_kind kind;
        falu_pkg::t_sat  res;
        logic            cmp;
        logic            neg;
        logic            dz;
    } t_dly;

    t_dly        n3;
    logic [63:0] prod_rnd;

    always_comb begin
        prod_rnd = (r2_prod + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        n3.v     = r2_v;
        n3.kind  = r2_kind;
        n3.res   = r2_res;
        n3.cmp   = r2_cmp;
        n3.neg   = r2_neg;
        n3.dz    = r2_dz;
        if (r2_kind == falu_pkg::K_MUL) begin
            n3.res = falu_pkg::sat_mag(r2_neg, prod_rnd);
        end
    end

    t_dly r_dly [DLY_N];

    for (genvar j = 0; j < DLY_N; j++) begin : g_dly
        t_dly dly_in;

        if (j == 0) begin : g_first
            assign dly_in = n3;
        end else begin : g_next
            assign dly_in = r_dly[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dly[j].v <= 1'b0;
            end else if (en) begin
                r_dly[j] <= dly_in;
            end
        end
    end

    // final select and output register
    t_dly           last;
    falu_pkg::t_sat n_out;
    assign last = r_dly[DLY_N-1];

    always_comb begin
        n_out = last.res;
        if (last.kind == falu_pkg::K_DIV) begin
            if (last.dz) begin
                n_out.fault = 1'b1;
                n_out.value = '0;
            end else begin
                n_out = falu_pkg::sat_mag(last.neg, 64'(div_quo));
            end
        end
    end

    logic        r_out_v;
    logic [31:0] r_out_value;
    logic        r_out_cmp;
    logic        r_out_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= last.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_value <= n_out.value;
            r_out_cmp   <= last.cmp;
            r_out_fault <= n_out.fault;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = {r_out_fault, r_out_cmp};

    logic out_cmp, out_fault, out_bound, out_stall;
    assign out_cmp   = o_m_axis_tvalid && o_m_axis_tuser[0];
    assign out_fault = o_m_axis_tvalid && o_m_axis_tuser[1];
    assign out_bound = (o_m_axis_tdata == falu_pkg::VAL_MAX)
                    || (o_m_axis_tdata == falu_pkg::VAL_MIN)
                    || (o_m_axis_tdata == '0);
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    // a comparison never faults and carries a zero value
    `FALU_ASSERT_SAME(a_cmp_no_fault, i_clk, i_rst_n, out_cmp, !o_m_axis_tuser[1])
    `FALU_ASSERT_SAME(a_cmp_zero, i_clk, i_rst_n, out_cmp, o_m_axis_tdata == '0)
    // a fault leaves a bound or zero
    `FALU_ASSERT_SAME(a_fault_val, i_clk, i_rst_n, out_fault, out_bound)
    // after a stalled output, either the output is still valid or the input side is ready
    `FALU_ASSERT_NEXT(a_stall_blocks, i_clk, i_rst_n, out_stall, o_m_axis_tvalid || o_s_axis_tready)

endmodule

`default_nettype wire

### tb/tb_fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_q24_8
// Self-checking bench for the Q24.8 saturating ALU. Operand beats are driven
// with random gaps, the output side stalls at random (once for a long stretch
// so the pipe backs up), and every result beat is compared with an exact
// integer prediction kept in order by a small scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fixed_point_alu_q24_8;

    localparam int FB = 8;
    localparam int LATENCY = FB + 34;
    localparam int N_RANDOM = 1500;

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic        fault;
    } t_alu_result;

    class alu_scoreboard;
        t_alu_result pending[$];
        int          errors;
        int          n_checked;

        function automatic t_alu_result saturate(logic signed [95:0] v);
            t_alu_result r;
            r = '0;
            if (v > 96'sh7FFF_FFFF) begin
                r.value = falu_pkg::VAL_MAX;
                r.fault = 1'b1;
            end else if (v < -96'sh8000_0000) begin
                r.value = falu_pkg::VAL_MIN;
                r.fault = 1'b1;
            end else begin
                r.value = v[31:0];
            end
            return r;
        endfunction

        function automatic t_alu_result compute(falu_pkg::t_kind k,
                                                logic signed [31:0] a,
                                                logic signed [31:0] b);
            t_alu_result        r;
            logic signed [95:0] wa, wb, p, q;
            logic [95:0]        ma, mb, n, quo, rem;
            r = '0;
            wa = a;
            wb = b;
            case (k)
                falu_pkg::K_ADD:     r = saturate(wa + wb);
                falu_pkg::K_SUB:     r = saturate(wa - wb);
                falu_pkg::K_INC:     r = saturate(wa + 1);
                falu_pkg::K_DEC:     r = saturate(wa - 1);
                falu_pkg::K_FROMINT: r = saturate(wa * (96'sd1 <<< FB));
                falu_pkg::K_MUL: begin
                    p = wa * wb;
                    ma = (p < 0) ? -p : p;
                    ma = (ma + (96'd1 << (FB - 1))) >> FB;
                    q = ma;
                    r = saturate((p < 0) ? -q : q);
                end
                falu_pkg::K_DIV: begin
                    if (b == 0) begin
                        r.fault = 1'b1;
                    end else begin
                        ma = (wa < 0) ? -wa : wa;
                        mb = (wb < 0) ? -wb : wb;
                        n = ma << FB;
                        quo = n / mb;
                        rem = n % mb;
                        if (rem >= mb - rem) quo = quo + 1;
                        q = quo;
                        r = saturate(((a < 0) != (b < 0)) ? -q : q);
                    end
                end
                falu_pkg::K_GT:    r.cmp = a > b;
                falu_pkg::K_LT:    r.cmp = a < b;
                falu_pkg::K_GE:    r.cmp = a >= b;
                falu_pkg::K_LE:    r.cmp = a <= b;
                falu_pkg::K_EQ:    r.cmp = a == b;
                falu_pkg::K_NE:    r.cmp = a != b;
                falu_pkg::K_MIN:   r.value = (a < b) ? a : b;
                falu_pkg::K_MAX:   r.value = (a > b) ? a : b;
                falu_pkg::K_TOINT: r.value = a >>> FB;
                default: ;
            endcase
            return r;
        endfunction

        function void note_operands(falu_pkg::t_kind k, logic [31:0] a, logic [31:0] b);
            pending.push_back(compute(k, a, b));
        endfunction

        function void check_result(logic [31:0] value, logic [1:0] flags);
            t_alu_result e;
            n_checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat value=%h flags=%b", $time, value, flags);
                return;
            end
            e = pending.pop_front();
            if (value !== e.value) begin
                errors++;
                $display("%0t: value expected %h actual %h", $time, e.value, value);
            end
            if (flags[0] !== e.cmp) begin
                errors++;
                $display("%0t: compare_true expected %b actual %b", $time, e.cmp, flags[0]);
            end
            if (flags[1] !== e.fault) begin
                errors++;
                $display("%0t: fault expected %b actual %b", $time, e.fault, flags[1]);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;
    logic [3:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    alu_scoreboard sb = new();
    int  n_sent = 0;
    bit  long_hold = 1'b0;
    bit  sending_done = 1'b0;

    fixed_point_alu_q24_8 #(.FRACTION_BITS(FB)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // one operand beat, with a random gap first; valid stays high across
    // back-to-back beats
    task automatic send_operands(falu_pkg::t_kind k, logic [31:0] a, logic [31:0] b);
        int gap;
        gap = $urandom_range(0, 13);
        if (n_sent % 300 >= 250) gap = 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b, a};
        i_s_axis_tuser  <= k;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_operands(k, a, b);
        n_sent++;
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return falu_pkg::VAL_MAX - $urandom_range(0, 2);
            1: return falu_pkg::VAL_MIN + $urandom_range(0, 2);
            2: return 32'($signed($urandom_range(0, 1024)) - 512);
            3: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
            4: return 32'($urandom_range(0, 255)) << 8;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] a, b;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < 16; k++) begin
            send_operands(falu_pkg::t_kind'(k), 32'h0000_0380, 32'hFFFF_FE80);
        end
        send_operands(falu_pkg::K_ADD, falu_pkg::VAL_MAX, 32'd1);
        send_operands(falu_pkg::K_SUB, falu_pkg::VAL_MIN, 32'd1);
        send_operands(falu_pkg::K_MUL, falu_pkg::VAL_MAX, falu_pkg::VAL_MAX);
        send_operands(falu_pkg::K_MUL, 32'h0000_0080, 32'h0000_0001);
        send_operands(falu_pkg::K_MUL, 32'hFFFF_FF80, 32'h0000_0001);
        send_operands(falu_pkg::K_DIV, 32'h0000_1234, 32'd0);
        send_operands(falu_pkg::K_DIV, falu_pkg::VAL_MIN, 32'hFFFF_FFFF);
        send_operands(falu_pkg::K_INC, falu_pkg::VAL_MAX, 32'd0);
        send_operands(falu_pkg::K_DEC, falu_pkg::VAL_MIN, 32'd0);
        send_operands(falu_pkg::K_FROMINT, falu_pkg::VAL_MIN, 32'd0);
        send_operands(falu_pkg::K_TOINT, 32'hFFFF_FFFF, falu_pkg::VAL_MAX);
        for (int i = 0; i < N_RANDOM; i++) begin
            a = pick_operand();
            b = pick_operand();
            if ($urandom_range(0, 9) == 0) b = a;
            if (i == 400) long_hold = 1'b1;
            send_operands(falu_pkg::t_kind'($urandom_range(0, 15)), a, b);
        end
        i_s_axis_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // random stalls on the result side, plus one long hold-off
    initial begin : result_side
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    initial begin : finish_run
        wait (sending_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4 * LATENCY) @(posedge i_clk);
        $display("Sent %0d operand beats over all 16 operations, checked %0d results,",
                 n_sent, sb.n_checked);
        $display("with random gaps on both sides and one long output hold-off.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
